### design/lam_pkg.sv
`timescale 1ns / 1ps
package lam_pkg;

    localparam logic [1:0] COL_LAST = 2'd3;

    typedef logic [2:0][31:0] vec3_t;
    typedef logic [2:0][32:0] dvec3_t;

    typedef struct packed {
        vec3_t  eye;
        vec3_t  hint;
        dvec3_t diff;
    } lam_item_t;

    typedef struct packed {
        vec3_t right;
        vec3_t up;
        vec3_t back;
        vec3_t shift;
    } lam_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SHIFT,
        ST_SQUARE,
        ST_RINIT,
        ST_ROOT,
        ST_DIVIDE,
        ST_STORE,
        ST_CROSS,
        ST_DOT,
        ST_DONE
    } eng_state_t;

    // cyclic successors used by the cross product
    function automatic logic [1:0] next1(input logic [1:0] j);
        logic [1:0] r;
        unique case (j)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] next2(input logic [1:0] j);
        logic [1:0] r;
        unique case (j)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

### design/lam_front.sv
`timescale 1ns / 1ps
module lam_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      eye_x,
    input  logic signed [31:0]      eye_y,
    input  logic signed [31:0]      eye_z,
    input  logic signed [31:0]      target_x,
    input  logic signed [31:0]      target_y,
    input  logic signed [31:0]      target_z,
    input  logic signed [31:0]      upward_x,
    input  logic signed [31:0]      upward_y,
    input  logic signed [31:0]      upward_z,
    input  logic                    q_full,
    output logic                    push,
    output lam_pkg::lam_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    lam_pkg::lam_item_t item_reg;
    lam_pkg::lam_item_t item_next;
    logic               accept;

    assign push     = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    // back vector before normalization
    always_comb
    begin
        item_next = item_reg;
        if (accept)
        begin
            item_next.eye     = {eye_z, eye_y, eye_x};
            item_next.hint    = {upward_z, upward_y, upward_x};
            item_next.diff[0] = {eye_x[31], eye_x} - {target_x[31], target_x};
            item_next.diff[1] = {eye_y[31], eye_y} - {target_y[31], target_y};
            item_next.diff[2] = {eye_z[31], eye_z} - {target_z[31], target_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### design/lam_queue.sv
`timescale 1ns / 1ps
module lam_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lam_pkg::lam_item_t push_item,
    output logic               full,
    output logic               not_empty,
    input  logic               pop,
    output lam_pkg::lam_item_t head
);

    lam_pkg::lam_item_t slot_reg [2];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_reg;
    logic               wr_next;
    logic               rd_reg;
    logic               rd_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        if (push)
        begin
            wr_next = !wr_reg;
        end
        if (pop)
        begin
            rd_next = !rd_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

### design/lam_engine.sv
`timescale 1ns / 1ps
module lam_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  lam_pkg::lam_item_t item,
    output logic               item_pop,
    output logic               res_valid,
    input  logic               res_take,
    output lam_pkg::lam_res_t  res
);

    localparam int VW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    lam_pkg::eng_state_t state_reg;
    lam_pkg::eng_state_t state_next;
    logic [1:0]          pass_reg;
    logic [1:0]          pass_next;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic [CW-1:0]       step_reg;
    logic [CW-1:0]       step_next;

    logic signed [31:0]    eye_reg   [3];
    logic signed [31:0]    eye_next  [3];
    logic signed [31:0]    hint_reg  [3];
    logic signed [31:0]    hint_next [3];
    logic signed [63:0]    vin_reg   [3];
    logic signed [63:0]    vin_next  [3];
    logic [62:0]           mag_reg   [3];
    logic [62:0]           mag_next  [3];
    logic [2:0]            neg_reg;
    logic [2:0]            neg_next;
    logic [63:0]           sum_reg;
    logic [63:0]           sum_next;
    logic [63:0]           rn_reg;
    logic [63:0]           rn_next;
    logic [63:0]           rres_reg;
    logic [63:0]           rres_next;
    logic [63:0]           rbit_reg;
    logic [63:0]           rbit_next;
    logic [31:0]           rem_reg   [3];
    logic [31:0]           rem_next  [3];
    logic [QW-1:0]         q_reg     [3];
    logic [QW-1:0]         q_next    [3];
    logic signed [VW-1:0]  back_reg  [3];
    logic signed [VW-1:0]  back_next [3];
    logic signed [VW-1:0]  right_reg [3];
    logic signed [VW-1:0]  right_next[3];
    logic signed [VW-1:0]  up_reg    [3];
    logic signed [VW-1:0]  up_next   [3];
    logic signed [63:0]    acc_reg;
    logic signed [63:0]    acc_next;
    logic [31:0]           shift_reg [3];
    logic [31:0]           shift_next[3];
    logic signed [63:0]    prod_reg;
    logic signed [63:0]    prod_next;

    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    logic signed [65:0]    mul_full;
    logic signed [32:0]    ca [3];
    logic signed [32:0]    cb [3];
    logic signed [32:0]    dv [3];
    logic [62:0]           mag_or;
    logic [1:0]            sel;
    logic [1:0]            n1;
    logic [1:0]            n2;
    logic [63:0]           r_trial;
    logic [32:0]           root33;
    logic [32:0]           cur      [3];
    logic [32:0]           dsub     [3];
    logic                  ge       [3];
    logic signed [VW-1:0]  qs       [3];
    logic [63:0]           t_mag;
    logic [63:0]           t_rnd;
    logic [63:0]           t_neg;
    logic [31:0]           t_term;

    function automatic logic signed [32:0] sx(input logic signed [VW-1:0] v);
        return {{(33 - VW){v[VW-1]}}, v};
    endfunction

    always_comb
    begin
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        sel     = (step_reg < CW'(3)) ? step_reg[1:0] : 2'd0;
        n1      = lam_pkg::next1(idx_reg);
        n2      = lam_pkg::next2(idx_reg);
        r_trial = rres_reg + rbit_reg;
        root33  = {1'b0, rres_reg[31:0]};
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = (pass_reg == 2'd1) ? {hint_reg[i][31], hint_reg[i]} : sx(back_reg[i]);
            cb[i] = (pass_reg == 2'd1) ? sx(back_reg[i]) : sx(right_reg[i]);
            unique case (idx_reg)
                2'd0:    dv[i] = sx(right_reg[i]);
                2'd1:    dv[i] = sx(up_reg[i]);
                default: dv[i] = sx(back_reg[i]);
            endcase
            cur[i]  = (step_reg == '0) ? {2'b00, mag_reg[i][30:0]} : {rem_reg[i], 1'b0};
            ge[i]   = cur[i] >= root33;
            dsub[i] = cur[i] - root33;
            qs[i]   = neg_reg[i] ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
        end
        t_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        t_rnd = (t_mag + HALF) >> FRAC_BITS;
        t_neg = 64'd0 - t_rnd;
        if (acc_reg[63])
        begin
            t_term = (t_rnd > 64'h8000_0000) ? 32'h8000_0000 : t_neg[31:0];
        end
        else
        begin
            t_term = (t_rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : t_rnd[31:0];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            lam_pkg::ST_SQUARE:
            begin
                mul_a = {2'b00, mag_reg[sel][30:0]};
                mul_b = {2'b00, mag_reg[sel][30:0]};
            end
            lam_pkg::ST_CROSS:
            begin
                mul_a = (step_reg == '0) ? ca[n1] : ca[n2];
                mul_b = (step_reg == '0) ? cb[n2] : cb[n1];
            end
            lam_pkg::ST_DOT:
            begin
                mul_a = dv[sel];
                mul_b = {eye_reg[sel][31], eye_reg[sel]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full  = mul_a * mul_b;
        prod_next = mul_full[63:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lam_pkg::ST_IDLE:
                if (item_valid) state_next = lam_pkg::ST_PREP;
            lam_pkg::ST_PREP:
                state_next = lam_pkg::ST_SHIFT;
            lam_pkg::ST_SHIFT:
                if (mag_or[62:31] == '0) state_next = lam_pkg::ST_SQUARE;
            lam_pkg::ST_SQUARE:
                if (step_reg == CW'(3)) state_next = lam_pkg::ST_RINIT;
            lam_pkg::ST_RINIT:
                state_next = (sum_reg == '0) ? lam_pkg::ST_STORE : lam_pkg::ST_ROOT;
            lam_pkg::ST_ROOT:
                if (rbit_reg[0]) state_next = lam_pkg::ST_DIVIDE;
            lam_pkg::ST_DIVIDE:
                if (step_reg == CW'(FRAC_BITS)) state_next = lam_pkg::ST_STORE;
            lam_pkg::ST_STORE:
                state_next = (pass_reg == 2'd2) ? lam_pkg::ST_DOT : lam_pkg::ST_CROSS;
            lam_pkg::ST_CROSS:
                if (idx_reg == 2'd2 && step_reg == CW'(2)) state_next = lam_pkg::ST_PREP;
            lam_pkg::ST_DOT:
                if (idx_reg == 2'd2 && step_reg == CW'(4)) state_next = lam_pkg::ST_DONE;
            lam_pkg::ST_DONE:
                if (res_take) state_next = lam_pkg::ST_IDLE;
            default:
                state_next = lam_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_pop  = (state_reg == lam_pkg::ST_IDLE) && item_valid;
        res_valid = state_reg == lam_pkg::ST_DONE;
    end

    always_comb
    begin
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        eye_next   = eye_reg;
        hint_next  = hint_reg;
        vin_next   = vin_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        rn_next    = rn_reg;
        rres_next  = rres_reg;
        rbit_next  = rbit_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        back_next  = back_reg;
        right_next = right_reg;
        up_next    = up_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        unique case (state_reg)
            lam_pkg::ST_IDLE:
            begin
                pass_next = 2'd0;
                for (int i = 0; i < 3; i++)
                begin
                    eye_next[i]  = item.eye[i];
                    hint_next[i] = item.hint[i];
                    vin_next[i]  = {{31{item.diff[i][32]}}, item.diff[i]};
                end
            end
            lam_pkg::ST_PREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = vin_reg[i][63];
                    mag_next[i] = vin_reg[i][63] ? 63'(-vin_reg[i]) : 63'(vin_reg[i]);
                end
                step_next = '0;
            end
            lam_pkg::ST_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mag_or[62:39] != '0)
                    begin
                        mag_next[i] = mag_reg[i] >> 8;
                    end
                    else if (mag_or[62:31] != '0)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
            end
            lam_pkg::ST_SQUARE:
            begin
                if (step_reg != '0)
                begin
                    sum_next = ((step_reg == CW'(1)) ? 64'd0 : sum_reg) + 64'(prod_reg);
                end
                step_next = step_reg + CW'(1);
            end
            lam_pkg::ST_RINIT:
            begin
                rn_next   = sum_reg;
                rres_next = '0;
                rbit_next = 64'd1 << 62;
                for (int i = 0; i < 3; i++)
                begin
                    q_next[i] = '0;
                end
            end
            lam_pkg::ST_ROOT:
            begin
                if (rn_reg >= r_trial)
                begin
                    rn_next   = rn_reg - r_trial;
                    rres_next = (rres_reg >> 1) + rbit_reg;
                end
                else
                begin
                    rres_next = rres_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                step_next = '0;
            end
            lam_pkg::ST_DIVIDE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = ge[i] ? dsub[i][31:0] : cur[i][31:0];
                    q_next[i]   = {q_reg[i][QW-2:0], ge[i]};
                end
                step_next = step_reg + CW'(1);
            end
            lam_pkg::ST_STORE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    unique case (pass_reg)
                        2'd0:    back_next[i]  = qs[i];
                        2'd1:    right_next[i] = qs[i];
                        default: up_next[i]    = qs[i];
                    endcase
                end
                pass_next = pass_reg + 2'd1;
                idx_next  = 2'd0;
                step_next = '0;
            end
            lam_pkg::ST_CROSS:
            begin
                if (step_reg == CW'(1))
                begin
                    acc_next = prod_reg;
                end
                if (step_reg == CW'(2))
                begin
                    vin_next[idx_reg] = acc_reg - prod_reg;
                    idx_next          = idx_reg + 2'd1;
                    step_next         = '0;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            lam_pkg::ST_DOT:
            begin
                if (step_reg != '0 && step_reg != CW'(4))
                begin
                    acc_next = ((step_reg == CW'(1)) ? 64'sd0 : acc_reg) - prod_reg;
                end
                if (step_reg == CW'(4))
                begin
                    shift_next[idx_reg] = t_term;
                    idx_next            = idx_reg + 2'd1;
                    step_next           = '0;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lam_pkg::ST_IDLE;
            pass_reg  <= 2'd0;
            idx_reg   <= 2'd0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg   <= eye_next;
        hint_reg  <= hint_next;
        vin_reg   <= vin_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        sum_reg   <= sum_next;
        rn_reg    <= rn_next;
        rres_reg  <= rres_next;
        rbit_reg  <= rbit_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        back_reg  <= back_next;
        right_reg <= right_next;
        up_reg    <= up_next;
        acc_reg   <= acc_next;
        shift_reg <= shift_next;
        prod_reg  <= prod_next;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res.right[i] = {{(32 - VW){right_reg[i][VW-1]}}, right_reg[i]};
            res.up[i]    = {{(32 - VW){up_reg[i][VW-1]}}, up_reg[i]};
            res.back[i]  = {{(32 - VW){back_reg[i][VW-1]}}, back_reg[i]};
            res.shift[i] = shift_reg[i];
        end
    end

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("engine popped an empty queue");

    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lam_pkg::ST_ROOT |-> $onehot(rbit_reg))
        else $error("square root bit lost");

    a_square_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lam_pkg::ST_SQUARE |->
            (mag_reg[0][62:31] == '0 && mag_reg[1][62:31] == '0
             && mag_reg[2][62:31] == '0))
        else $error("magnitude too wide for squaring");

    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> state_reg == lam_pkg::ST_IDLE)
        else $error("engine did not release after hand-off");

endmodule

### design/lam_emit.sv
`timescale 1ns / 1ps
module lam_emit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_take,
    input  lam_pkg::lam_res_t   res,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          column_index,
    output logic signed [31:0]  right_part,
    output logic signed [31:0]  up_part,
    output logic signed [31:0]  back_part,
    output logic signed [31:0]  shift_part,
    output logic                last_column
);

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic              busy_reg;
    logic              busy_next;
    logic [1:0]        col_reg;
    logic [1:0]        col_next;
    lam_pkg::lam_res_t data_reg;
    lam_pkg::lam_res_t data_next;
    logic              sent;
    logic              is_last;

    assign is_last   = col_reg == lam_pkg::COL_LAST;
    assign out_valid = busy_reg;
    assign sent      = busy_reg && !out_stall;
    assign res_take  = res_valid && (!busy_reg || (sent && is_last));

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        data_next = data_reg;
        if (res_take)
        begin
            busy_next = 1'b1;
            col_next  = 2'd0;
            data_next = res;
        end
        else if (sent)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        column_index = col_reg;
        last_column  = is_last;
        unique case (col_reg)
            2'd0:
            begin
                right_part = data_reg.right[0];
                up_part    = data_reg.up[0];
                back_part  = data_reg.back[0];
                shift_part = data_reg.shift[0];
            end
            2'd1:
            begin
                right_part = data_reg.right[1];
                up_part    = data_reg.up[1];
                back_part  = data_reg.back[1];
                shift_part = data_reg.shift[1];
            end
            2'd2:
            begin
                right_part = data_reg.right[2];
                up_part    = data_reg.up[2];
                back_part  = data_reg.back[2];
                shift_part = data_reg.shift[2];
            end
            lam_pkg::COL_LAST:
            begin
                right_part = '0;
                up_part    = '0;
                back_part  = '0;
                shift_part = ONE;
            end
        endcase
    end

endmodule

### design/look_at_view_matrix_top.sv
`timescale 1ns / 1ps
// look-at view matrix from eye, target and up hint, all signed fixed point
// input channel: in_valid / in_stall carry one request of nine coordinates
// output channel: out_valid / out_stall carry four column results per request,
//   columns 0 to 3 in order, last_column high on column 3 (0, 0, 0, 1.0)
// a front stage takes the request and forms eye minus target, a two-entry
//   queue buffers requests, an engine with one shared 33x33 multiplier, a
//   bit-serial square root and three bit-serial dividers normalizes the
//   three vectors and forms the translation terms
// per request the engine runs, once for each vector, its normalizing shifts,
//   the 32-step square root and the FRAC_BITS + 1 step divide
// the first column is driven from the column register once the engine's
//   result is taken into it; further requests are taken into the front and
//   queue while the engine works
// the column register holds its result while out_stall is high; the engine
//   finishes the next request and waits for the columns to drain
// reset clears all valid and state flags; no result is pending afterward
module look_at_view_matrix_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] upward_x,
    input  logic signed [31:0] upward_y,
    input  logic signed [31:0] upward_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         column_index,
    output logic signed [31:0] right_part,
    output logic signed [31:0] up_part,
    output logic signed [31:0] back_part,
    output logic signed [31:0] shift_part,
    output logic               last_column
);

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    logic               res_valid;
    logic               res_take;
    lam_pkg::lam_item_t front_item;
    lam_pkg::lam_item_t head_item;
    lam_pkg::lam_res_t  res;

    lam_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .eye_x    (eye_x),
        .eye_y    (eye_y),
        .eye_z    (eye_z),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .upward_x (upward_x),
        .upward_y (upward_y),
        .upward_z (upward_z),
        .q_full   (q_full),
        .push     (push),
        .item     (front_item)
    );

    lam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (pop),
        .head      (head_item)
    );

    lam_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (head_item),
        .item_pop   (pop),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    lam_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_index (column_index),
        .right_part   (right_part),
        .up_part      (up_part),
        .back_part    (back_part),
        .shift_part   (shift_part),
        .last_column  (last_column)
    );

endmodule
